// File: src/gbr_pkg.sv
// Shared types, constants and the Gaussian weight table of the RGB blur.
`timescale 1ns / 1ps
package gbr_pkg;

  localparam int unsigned RADIUS    = 8;
  localparam int unsigned TAPS      = 2 * RADIUS + 1;
  localparam int unsigned RING_ROWS = 2 * RADIUS + 2;
  localparam int unsigned TAP_IDX_W = 5;
  localparam int unsigned RING_W    = 5;
  localparam int unsigned WGT_W     = 14;
  localparam int unsigned WPROD_W   = 27;
  localparam int unsigned PROD_W    = 35;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned FRAC_SH   = 32;
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned PIX_W     = 24;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd17;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd17;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // Command codes of an input item
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Control of one window tap travelling with its memory read
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [3:0] ax;
    logic [3:0] ay;
  } mac_ctrl_t;

  // Half kernel: weight of a tap at distance a from the center, Q0.16
  function automatic logic [WGT_W-1:0] tap_weight(input logic [3:0] a);
    logic [WGT_W-1:0] w;
    case (a)
      4'd0:    w = 14'd8754;
      4'd1:    w = 14'd8281;
      4'd2:    w = 14'd7009;
      4'd3:    w = 14'd5309;
      4'd4:    w = 14'd3599;
      4'd5:    w = 14'd2183;
      4'd6:    w = 14'd1185;
      4'd7:    w = 14'd575;
      4'd8:    w = 14'd250;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

// File: src/gbr_if.sv
// Handshake interfaces for pixel items, result items and configuration writes.
`timescale 1ns / 1ps
interface gbr_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface gbr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;
  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface gbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/gbr_line_store.sv
// Line store: ring of image rows in one synchronous memory, registered read.
`timescale 1ns / 1ps
module gbr_line_store
  import gbr_pkg::*;
#(
  parameter int unsigned DEPTH = 18432,
  parameter int unsigned AW    = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gbr_mac.sv
// Weighted accumulate of window taps: weight product, channel products, sum.
`timescale 1ns / 1ps
module gbr_mac
  import gbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_ctrl_t        ctrl_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic             done_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o
);

  mac_ctrl_t          s1_q, s2_q;
  logic [WPROD_W-1:0] wprod_q;
  logic [PIX_W-1:0]   pix_q;
  logic [PROD_W-1:0]  prod_q [3];
  logic [ACC_W-1:0]   acc_q  [3];
  logic               done_q;
  logic [2*WGT_W-1:0] wprod_full;

  assign wprod_full = tap_weight(ctrl_i.ax) * tap_weight(ctrl_i.ay);

  // Advance control through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= ctrl_i;
      s2_q   <= s1_q;
      done_q <= s2_q.vld && s2_q.last;
    end
  end

  // Stage one: combined 2-D weight
  always_ff @(posedge clk_i) begin
    wprod_q <= wprod_full[WPROD_W-1:0];
    pix_q   <= pix_i;
  end

  // Stage two: per-channel products
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= PROD_W'(wprod_q) * PROD_W'(pix_q[8*(2-c) +: 8]);
    end
  end

  // Stage three: accumulate, restart on the first tap
  always_ff @(posedge clk_i) begin
    if (s2_q.vld) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= (s2_q.first ? '0 : acc_q[c]) + ACC_W'(prod_q[c]);
      end
    end
  end

  assign done_o  = done_q;
  assign red_o   = acc_q[0][FRAC_SH +: 8];
  assign green_o = acc_q[1][FRAC_SH +: 8];
  assign blue_o  = acc_q[2][FRAC_SH +: 8];

endmodule

// File: src/gaussian_blur_rgb_17x17_top.sv
// Top level of the streaming 17x17 Gaussian blur for RGB888 pixels.
// An item that yields no result leaves the block idle; one that yields a
// result runs through the acceptance, 289 line store reads (one window
// tap per cycle), three multiply-accumulate stages, a state that sees the sum
// finish and one output load, held while the output register is full.
// The result waits in an output register; the next item is taken meanwhile.
// Reset (asynchronous, active low) restores 640x480 and starts a new frame.
`timescale 1ns / 1ps
module gaussian_blur_rgb_17x17_top
  import gbr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbr_pix_if.sink   pix_i,
  gbr_res_if.source res_o,
  gbr_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [WIDTH_W-1:0]   width_q;
  logic [HEIGHT_W-1:0]  height_q;
  logic [WIDTH_W-1:0]   ew;
  logic [HEIGHT_W-1:0]  eh;
  logic [WIDTH_W-1:0]   in_col_q, out_col_q;
  logic [HEIGHT_W-1:0]  in_row_q, out_row_q;
  logic [RING_W-1:0]    in_ring_q, out_ring_q;
  logic                 in_done_q;
  logic [TAP_IDX_W-1:0] dy_q, dx_q;
  mac_ctrl_t            ctrl_q;
  logic                 out_valid_q;
  logic [7:0]           red_q, green_q, blue_q;
  logic                 last_q;

  logic                 pix_acc, cfg_acc, wr_pix, start, run, load;
  logic                 in_last, out_last, tap_first, tap_last;
  logic signed [13:0]   u_row;
  logic signed [5:0]    d_row;
  logic signed [6:0]    ring_s;
  logic [RING_W-1:0]    rd_ring;
  logic signed [12:0]   c_col;
  logic [WIDTH_W-1:0]   rd_col;
  logic [AW-1:0]        waddr, raddr;
  logic [PIX_W-1:0]     rdata;
  logic                 mac_done;
  logic [7:0]           mac_r, mac_g, mac_b;

  // Effective frame size
  always_comb begin
    if (width_q < WIDTH_MIN) begin
      ew = WIDTH_MIN;
    end else if ({2'b00, width_q} > 13'(MAX_WIDTH)) begin
      ew = WIDTH_W'(MAX_WIDTH);
    end else begin
      ew = width_q;
    end
    eh = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
  end

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign pix_i.ready = (state_q == ST_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign wr_pix      = pix_acc && (pix_i.cmd == CMD_PIXEL) && !in_done_q;
  assign in_last     = (in_row_q == eh - 1'b1) && (in_col_q == ew - 1'b1);
  assign out_last    = (out_row_q == eh - 1'b1) && (out_col_q == ew - 1'b1);
  assign start = (wr_pix && ((in_row_q > HEIGHT_W'(RADIUS)) ||
                  ((in_row_q == HEIGHT_W'(RADIUS)) && (in_col_q >= WIDTH_W'(RADIUS)))))
              || (pix_acc && (pix_i.cmd == CMD_DRAIN) && in_done_q);
  assign run       = (state_q == ST_RUN);
  assign load      = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);
  assign tap_first = (dy_q == '0) && (dx_q == '0);
  assign tap_last  = (dy_q == TAP_IDX_W'(TAPS - 1)) && (dx_q == TAP_IDX_W'(TAPS - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_RUN;
      ST_RUN:  if (tap_last) state_d = ST_WAIT;
      ST_WAIT: if (mac_done) state_d = ST_FIN;
      ST_FIN:  if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring row of the clamped source row for this tap
  always_comb begin
    u_row = signed'({2'b00, out_row_q}) + signed'({9'd0, dy_q}) - 14'sd8;
    if (u_row < 14'sd0) begin
      d_row = -signed'({1'b0, out_row_q[4:0]});
    end else if (u_row > signed'({2'b00, eh}) - 14'sd1) begin
      d_row = 6'(eh - 1'b1 - out_row_q);
    end else begin
      d_row = signed'({1'b0, dy_q}) - 6'sd8;
    end
    ring_s = signed'({2'b00, out_ring_q}) + 7'(d_row);
    if (ring_s < 7'sd0) begin
      ring_s = ring_s + 7'sd18;
    end else if (ring_s >= 7'sd18) begin
      ring_s = ring_s - 7'sd18;
    end
    rd_ring = RING_W'(ring_s);
  end

  // Clamped source column for this tap
  always_comb begin
    c_col = signed'({2'b00, out_col_q}) + signed'({8'd0, dx_q}) - 13'sd8;
    if (c_col < 13'sd0) begin
      rd_col = '0;
    end else if (c_col > signed'({2'b00, ew}) - 13'sd1) begin
      rd_col = ew - 1'b1;
    end else begin
      rd_col = WIDTH_W'(c_col);
    end
  end

  assign waddr = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign raddr = AW'(rd_ring) * AW'(MAX_WIDTH) + AW'(rd_col);

  gbr_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_pix),
    .waddr_i (waddr),
    .wdata_i ({pix_i.red_in, pix_i.green_in, pix_i.blue_in}),
    .re_i    (run),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gbr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_q),
    .pix_i   (rdata),
    .done_o  (mac_done),
    .red_o   (mac_r),
    .green_o (mac_g),
    .blue_o  (mac_b)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_ring_q   <= '0;
      in_done_q   <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_ring_q  <= '0;
      dy_q        <= '0;
      dx_q        <= '0;
      ctrl_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      // Tag the tap that travels with this read
      ctrl_q.vld   <= run;
      ctrl_q.first <= tap_first;
      ctrl_q.last  <= tap_last;
      ctrl_q.ax    <= (dx_q >= TAP_IDX_W'(RADIUS)) ? 4'(dx_q - TAP_IDX_W'(RADIUS))
                                                   : 4'(TAP_IDX_W'(RADIUS) - dx_q);
      ctrl_q.ay    <= (dy_q >= TAP_IDX_W'(RADIUS)) ? 4'(dy_q - TAP_IDX_W'(RADIUS))
                                                   : 4'(TAP_IDX_W'(RADIUS) - dy_q);
      // Step through the window taps
      if (start) begin
        dy_q <= '0;
        dx_q <= '0;
      end else if (run) begin
        if (dx_q == TAP_IDX_W'(TAPS - 1)) begin
          dx_q <= '0;
          dy_q <= dy_q + 1'b1;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end
      // Advance the input position
      if (wr_pix) begin
        if (in_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_ring_q <= '0;
          in_done_q <= 1'b1;
        end else if (in_col_q == ew - 1'b1) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 1'b1;
          in_ring_q <= (in_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      // Drop the result once taken, load the next one
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        last_q      <= out_last;
        if (out_last) begin
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_ring_q <= '0;
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_ring_q  <= '0;
          in_done_q  <= 1'b0;
        end else if (out_col_q == ew - 1'b1) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_ring_q <= (out_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : out_ring_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
      // Register writes restart the frame
      if (cfg_acc) begin
        unique case (cfg_i.index)
          REG_WIDTH:  width_q  <= cfg_i.data[WIDTH_W-1:0];
          REG_HEIGHT: height_q <= cfg_i.data;
          default:    ;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        in_done_q  <= 1'b0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= mac_r;
      green_q <= mac_g;
      blue_q  <= mac_b;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.red_out    = red_q;
  assign res_o.green_out  = green_q;
  assign res_o.blue_out   = blue_q;
  assign res_o.frame_last = last_q;

  // Checks
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_WAIT))
    else $error("accumulator finished outside the wait state");

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ring_q < RING_W'(RING_ROWS)) && (out_ring_q < RING_W'(RING_ROWS)))
    else $error("ring row out of range");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (32'(raddr) < DEPTH))
    else $error("line store read beyond depth");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_done_q |-> ((in_col_q == '0) && (in_row_q == '0)))
    else $error("input position not cleared at end of frame");

  a_no_pixel_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> !$past(wr_pix))
    else $error("pixel written during a window sweep");

endmodule
